FILE: rtl/core/msosc_pkg.sv
// Package for the note-driven sine oscillator: types, constants and ROM contents.
package msosc_pkg;

    localparam int PHASE_BITS    = 32;
    localparam int SINE_ADDR_W   = 10;
    localparam int SINE_DEPTH    = 1 << SINE_ADDR_W;
    localparam int NOTE_W        = 7;
    localparam int NOTE_COUNT    = 1 << NOTE_W;
    localparam int VEL_W         = 7;
    localparam int SAMPLE_W      = 16;
    localparam int CC_W          = 24;
    localparam int CC_VALUE_W    = 7;

    localparam logic [CC_W-1:0]       CC_PERIOD_RESET = CC_W'(44100);
    localparam logic [CC_VALUE_W-1:0] CC_VALUE_HIGH   = CC_VALUE_W'(127);
    localparam logic [CC_VALUE_W-1:0] CC_VALUE_LOW    = '0;

    localparam longint unsigned SAMPLE_RATE = 64'd44100;
    localparam longint unsigned SIN_A       = 64'd51472;
    localparam longint unsigned SIN_B       = 64'd21024;
    localparam longint unsigned SIN_C       = 64'd2320;
    localparam longint unsigned SIN_MAX     = 64'd32767;
    localparam longint unsigned SINE_SPAN   = 64'(SINE_DEPTH);

    typedef enum logic
    {
        FUNC_TICK    = 1'b0,
        FUNC_NOTE_ON = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t             func;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } in_item_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       cc_send;
        logic [CC_VALUE_W-1:0]      cc_value;
    } out_item_t;

    typedef struct packed
    {
        logic [VEL_W-1:0]      vel;
        logic                  gate;
        logic                  cc_send;
        logic [CC_VALUE_W-1:0] cc_value;
    } tick_info_t;

    typedef logic [PHASE_BITS-1:0]      step_rom_t [NOTE_COUNT];
    typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_DEPTH];

    // one octave of note frequencies in Q8.24, notes 0 to 11
    localparam logic [31:0] OCTAVE_BASE_Q24 [12] = '{
        32'd137167144, 32'd145323527, 32'd153964914, 32'd163120144,
        32'd172819773, 32'd183096171, 32'd193983636, 32'd205518503,
        32'd217739269, 32'd230686720, 32'd244404066, 32'd258937088
    };

    // PHASE_BITS is at least 24, so the octave shift is never negative
    function automatic step_rom_t build_step_rom();
        step_rom_t       rom;
        longint unsigned x;
        longint unsigned q;
        longint unsigned rm;
        longint unsigned r;
        int              e;
        for (int n = 0; n < NOTE_COUNT; n++)
        begin
            x  = 64'(OCTAVE_BASE_Q24[n % 12]);
            e  = n / 12 + PHASE_BITS - 24;
            q  = x / SAMPLE_RATE;
            rm = x % SAMPLE_RATE;
            r  = (q << e) + (((rm << e) + SAMPLE_RATE / 2) / SAMPLE_RATE);
            rom[n] = r[PHASE_BITS-1:0];
        end
        return rom;
    endfunction

    // quarter-wave odd polynomial, mirrored and negated per quadrant
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned t;
        longint unsigned quad;
        longint unsigned rr;
        longint unsigned pos;
        longint unsigned xq;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned y;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            t    = 64'(i) * 64'd4;
            quad = (t / SINE_SPAN) & 64'd3;
            rr   = t % SINE_SPAN;
            pos  = quad[0] ? (SINE_SPAN - rr) : rr;
            xq   = (pos << 15) / SINE_SPAN;
            x2   = (xq * xq) >> 15;
            p    = SIN_B - ((SIN_C * x2) >> 15);
            p    = SIN_A - ((p * x2) >> 15);
            y    = (xq * p) >> 15;
            if (y > SIN_MAX)
            begin
                y = SIN_MAX;
            end
            rom[i] = quad[1] ? SAMPLE_W'(-y) : SAMPLE_W'(y);
        end
        return rom;
    endfunction

    localparam step_rom_t STEP_ROM = build_step_rom();
    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/core/msosc_sine_rom.sv
// Sine table ROM with registered read.
module msosc_sine_rom
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [msosc_pkg::SINE_ADDR_W-1:0]    addr,
    output logic signed [msosc_pkg::SAMPLE_W-1:0] rd_data
);
    import msosc_pkg::*;

    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg <= SINE_ROM[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/msosc_voice.sv
// Oscillator state: phase accumulator, note step, gate and control-change counter.
module msosc_voice
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  msosc_pkg::in_item_t               item,
    input  logic                              cfg_we,
    input  logic [msosc_pkg::CC_W-1:0]        cfg_wdata,
    output logic [msosc_pkg::SINE_ADDR_W-1:0] rom_addr,
    output msosc_pkg::tick_info_t             info
);
    import msosc_pkg::*;

    logic [PHASE_BITS-1:0] phase_acc_reg,  phase_acc_next;
    logic [PHASE_BITS-1:0] phase_step_reg, phase_step_next;
    logic [VEL_W-1:0]      vel_reg,        vel_next;
    logic                  gate_reg,       gate_next;
    logic [CC_W-1:0]       tick_count_reg, tick_count_next;
    logic                  cc_level_reg,   cc_level_next;
    logic [CC_W-1:0]       cc_period_reg;

    logic [PHASE_BITS-1:0] phase_sum;
    logic [CC_W-1:0]       period;
    logic [CC_W:0]         count_inc;
    logic                  cc_due;

    assign phase_sum = phase_acc_reg + phase_step_reg;
    assign period    = (cc_period_reg == '0) ? CC_W'(1) : cc_period_reg;
    assign count_inc = {1'b0, tick_count_reg} + (CC_W+1)'(1);
    assign cc_due    = (tick_count_reg == '0);

    always_comb
    begin
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        vel_next        = vel_reg;
        gate_next       = gate_reg;
        tick_count_next = tick_count_reg;
        cc_level_next   = cc_level_reg;
        if (accept)
        begin
            unique case (item.func)
                FUNC_NOTE_ON:
                begin
                    phase_step_next = STEP_ROM[item.note];
                    vel_next        = item.velocity;
                    gate_next       = (item.velocity != '0);
                end
                FUNC_TICK:
                begin
                    if (gate_reg)
                    begin
                        phase_acc_next = phase_sum;
                    end
                    if (cc_due)
                    begin
                        cc_level_next = ~cc_level_reg;
                    end
                    tick_count_next = (count_inc >= {1'b0, period}) ? '0
                                                                     : count_inc[CC_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            vel_reg        <= '0;
            gate_reg       <= 1'b0;
            tick_count_reg <= '0;
            cc_level_reg   <= 1'b0;
            cc_period_reg  <= CC_PERIOD_RESET;
        end
        else
        begin
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            vel_reg        <= vel_next;
            gate_reg       <= gate_next;
            tick_count_reg <= tick_count_next;
            cc_level_reg   <= cc_level_next;
            if (cfg_we)
            begin
                cc_period_reg <= cfg_wdata;
            end
        end
    end

    assign rom_addr      = phase_sum[PHASE_BITS-1 -: SINE_ADDR_W];
    assign info.vel      = vel_reg;
    assign info.gate     = gate_reg;
    assign info.cc_send  = cc_due;
    assign info.cc_value = cc_level_next ? CC_VALUE_HIGH : CC_VALUE_LOW;

endmodule

FILE: rtl/core/msosc_scale.sv
// Velocity scaling of the table value and the output register.
module msosc_scale
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  logic signed [msosc_pkg::SAMPLE_W-1:0] rom_data,
    input  msosc_pkg::tick_info_t                 info,
    input  logic                                  smp_ready,
    output logic                                  smp_valid,
    output msosc_pkg::out_item_t                  smp
);
    import msosc_pkg::*;

    localparam int PROD_W = SAMPLE_W + VEL_W + 1;

    logic                     valid_reg;
    out_item_t                smp_reg, smp_next;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;

    // divide by 128, truncating toward zero
    assign prod   = rom_data * $signed({1'b0, info.vel});
    assign biased = prod + (prod[PROD_W-1] ? PROD_W'(127) : PROD_W'(0));

    always_comb
    begin
        smp_next.sample   = info.gate ? SAMPLE_W'(biased >>> 7) : '0;
        smp_next.cc_send  = info.cc_send;
        smp_next.cc_value = info.cc_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (smp_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            smp_reg <= smp_next;
        end
    end

    assign smp_valid = valid_reg;
    assign smp       = smp_reg;

endmodule

FILE: rtl/core/midi_note_sine_oscillator.sv
// Top level of the note-driven sine oscillator with control-change pulse.
// Takes one item per clock cycle unless input is held off. A note-on item loads
// the phase step, velocity and gate and gives no result; a sample tick gives
// one result: the sine table is read as the tick is taken, and the velocity
// multiply then loads the output register once that is free. Input is held
// off only while a result stays untaken in the output register with the next
// one behind it. cc_period may be written only while the block is idle.
module midi_note_sine_oscillator
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  msosc_pkg::in_item_t        cmd,
    output logic                       smp_valid,
    input  logic                       smp_ready,
    output msosc_pkg::out_item_t       smp,
    input  logic                       cfg_we,
    input  logic [msosc_pkg::CC_W-1:0] cfg_wdata
);
    import msosc_pkg::*;

    logic                       accept;
    logic                       out_adv;
    logic                       out_load;
    logic [SINE_ADDR_W-1:0]     rom_addr;
    logic signed [SAMPLE_W-1:0] rom_data;
    tick_info_t                 info;
    logic                       s1_valid_reg, s1_valid_next;
    tick_info_t                 s1_info_reg;

    assign out_adv   = ~smp_valid | smp_ready;
    assign cmd_ready = ~s1_valid_reg | out_adv;
    assign accept    = cmd_valid & cmd_ready;
    assign out_load  = s1_valid_reg & out_adv;

    msosc_voice u_voice
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rom_addr  (rom_addr),
        .info      (info)
    );

    msosc_sine_rom u_rom
    (
        .clk     (clk),
        .en      (cmd_ready),
        .addr    (rom_addr),
        .rd_data (rom_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_ready)
        begin
            s1_valid_next = accept & (cmd.func == FUNC_TICK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready)
        begin
            s1_info_reg <= info;
        end
    end

    msosc_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .rom_data  (rom_data),
        .info      (s1_info_reg),
        .smp_ready (smp_ready),
        .smp_valid (smp_valid),
        .smp       (smp)
    );

    a_note_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.func == FUNC_NOTE_ON) |=> !s1_valid_reg)
        else $error("note-on item entered the result pipeline");

    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.func == FUNC_TICK) |=> s1_valid_reg)
        else $error("sample tick lost before the table read stage");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> (s1_valid_reg && smp_valid && !smp_ready))
        else $error("input held off without a blocked output");

    a_gate_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !s1_info_reg.gate) |=> (smp.sample == '0))
        else $error("gate off but sample not silent");

endmodule
